/* sv/ald_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ald_pkg
// Shared constants and types of the ambient light display dimmer.
// ----------------------------------------------------------------------------
package ald_pkg;

   localparam int STEPS      = 4;
   localparam int ON_W       = $clog2(STEPS + 1);
   localparam int PH_W       = $clog2(STEPS);
   localparam int LIGHT_W    = 10;
   localparam int CMD_W      = 8;
   localparam int LVL_W      = 3;
   localparam int APP_W      = 4;
   localparam int BRIGHT_MAX = 512;
   localparam int DIM_SPAN   = 511;

   localparam logic [CMD_W-1:0] CMD_ON  = 8'h88;
   localparam logic [CMD_W-1:0] CMD_OFF = 8'h80;
   localparam logic [LVL_W-1:0] LEVEL_MAX     = 3'd7;
   localparam logic [APP_W-1:0] LEVEL_UNKNOWN = 4'hf;
   localparam logic [APP_W-1:0] COUNT_UNKNOWN = 4'hf;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_BRIGHT  = 2'd0,
      MODE_DIM     = 2'd1,
      MODE_UNKNOWN = 2'd3
   } ald_mode_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             last;
   } ald_entry_type;

   typedef struct packed {
      logic [1:0]    count;
      ald_entry_type e0;
      ald_entry_type e1;
   } ald_push_type;

endpackage

/* sv/ald_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ald_fifo
// Response queue, takes up to two entries per cycle and hands out one per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module ald_fifo import ald_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  ald_push_type     push,
   output logic             room,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [CMD_W-1:0] rsp_command,
   output logic             rsp_last
);

   ald_entry_type        mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic                 pop;
   logic [FIFO_AW-1:0]   wr_ptr_1;

   assign room        = count_ff <= FIFO_CW'(FIFO_DEPTH - 2);
   assign rsp_valid   = count_ff != '0;
   assign rsp_command = mem_ff[rd_ptr_ff].command;
   assign rsp_last    = mem_ff[rd_ptr_ff].last;
   assign pop         = rsp_valid & ~rsp_stall;
   assign wr_ptr_1    = wr_ptr_ff + FIFO_AW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(push.count);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + FIFO_CW'(push.count) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.e0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_1] <= push.e1;
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CW'(FIFO_DEPTH))
      else $error("response queue count out of range");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> count_ff <= FIFO_CW'(FIFO_DEPTH - 2))
      else $error("push without room in response queue");
`endif

endmodule

/* sv/ald_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ald_core
// Request register, dimmer state and command generation.
// ----------------------------------------------------------------------------
module ald_core import ald_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [LIGHT_W-1:0] req_light,
   input  logic               room,
   output ald_push_type       push
);

   localparam int DX_W   = LIGHT_W - 1;
   localparam int PROD_W = DX_W + PH_W;
   localparam int LP_W   = LIGHT_W + 3;

   function automatic logic [ON_W-1:0] dim_on(input logic [LIGHT_W-1:0] light);
      logic [DX_W-1:0]   dx;
      logic [PROD_W-1:0] prod;
      logic [ON_W-1:0]   q;
      dx   = DX_W'(light - LIGHT_W'(BRIGHT_MAX));
      prod = PROD_W'(dx) * PROD_W'(STEPS - 1);
      q    = '0;
      for (int k = 1; k < STEPS; k++) begin
         if (prod >= PROD_W'(k * DIM_SPAN)) begin
            q = q + ON_W'(1);
         end
      end
      return ON_W'(STEPS) - q;
   endfunction

   logic               in_valid_ff;
   logic               in_op_ff;
   logic [LIGHT_W-1:0] in_light_ff;

   logic [LVL_W-1:0]   level_ff, level_in;
   logic               pwm_en_ff, pwm_en_in;
   logic [ON_W-1:0]    on_count_ff, on_count_in;
   logic [PH_W-1:0]    phase_ff, phase_in;
   logic [APP_W-1:0]   app_level_ff, app_level_in;
   logic [APP_W-1:0]   app_on_ff, app_on_in;
   ald_mode_type       mode_ff, mode_in;

   logic               fire;
   logic               take;
   logic [LP_W-1:0]    lvl_prod;
   logic [LVL_W-1:0]   lvl;
   logic [ON_W-1:0]    on_val;
   logic [PH_W-1:0]    phase_nx;
   logic               leaving;
   logic               change;

   assign fire      = in_valid_ff & room;
   assign req_stall = in_valid_ff & ~fire;
   assign take      = req_valid & ~req_stall;

   assign lvl_prod = LP_W'(in_light_ff) * LP_W'(7);
   assign lvl      = LEVEL_MAX - lvl_prod[LVL_W+8:9];
   assign on_val   = dim_on(in_light_ff);
   assign phase_nx = (phase_ff == PH_W'(STEPS - 1)) ? '0 : phase_ff + PH_W'(1);
   assign leaving  = mode_ff != MODE_BRIGHT;
   assign change   = (APP_W'(lvl) != app_level_ff) || leaving;

   always_comb begin
      level_in     = level_ff;
      pwm_en_in    = pwm_en_ff;
      on_count_in  = on_count_ff;
      phase_in     = phase_ff;
      app_level_in = app_level_ff;
      app_on_in    = app_on_ff;
      mode_in      = mode_ff;
      push.count   = 2'd0;
      push.e0      = '{command: CMD_ON | CMD_W'(level_ff), last: 1'b1};
      push.e1      = '{command: CMD_ON | CMD_W'(lvl), last: 1'b1};
      if (fire) begin
         if (in_op_ff) begin
            if (pwm_en_ff) begin
               phase_in   = phase_nx;
               push.count = 2'd1;
               push.e0.command = (ON_W'(phase_nx) < on_count_ff) ?
                                 (CMD_ON | CMD_W'(level_ff)) : CMD_OFF;
            end
         end else if (in_light_ff <= LIGHT_W'(BRIGHT_MAX)) begin
            if (change) begin
               level_in     = lvl;
               app_level_in = APP_W'(lvl);
               push.count   = leaving ? 2'd2 : 2'd1;
               push.e0      = '{command: CMD_ON | CMD_W'(lvl), last: ~leaving};
            end
            if (leaving) begin
               pwm_en_in   = 1'b0;
               on_count_in = ON_W'(STEPS);
               phase_in    = '0;
               mode_in     = MODE_BRIGHT;
               app_on_in   = APP_W'(STEPS);
            end
         end else begin
            if (app_level_ff != '0) begin
               level_in     = '0;
               app_level_in = '0;
               push.count   = 2'd1;
               push.e0      = '{command: CMD_ON, last: 1'b1};
            end
            if (mode_ff != MODE_DIM || app_on_ff != APP_W'(on_val)) begin
               pwm_en_in   = 1'b1;
               on_count_in = on_val;
               mode_in     = MODE_DIM;
               app_on_in   = APP_W'(on_val);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         level_ff     <= LEVEL_MAX;
         pwm_en_ff    <= 1'b0;
         on_count_ff  <= ON_W'(STEPS);
         phase_ff     <= '0;
         app_level_ff <= LEVEL_UNKNOWN;
         app_on_ff    <= COUNT_UNKNOWN;
         mode_ff      <= MODE_UNKNOWN;
      end else begin
         in_valid_ff  <= take | (in_valid_ff & ~fire);
         level_ff     <= level_in;
         pwm_en_ff    <= pwm_en_in;
         on_count_ff  <= on_count_in;
         phase_ff     <= phase_in;
         app_level_ff <= app_level_in;
         app_on_ff    <= app_on_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff    <= req_op;
         in_light_ff <= req_light;
      end
   end

`ifndef SYNTHESIS
   a_on_count_range: assert property (@(posedge clock) disable iff (reset)
      on_count_ff != '0 && on_count_ff <= ON_W'(STEPS))
      else $error("pwm on count out of range");

   a_two_last: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> !push.e0.last && push.e1.last)
      else $error("last flag wrong on two-command request");

   a_bright_pwm_off: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_BRIGHT |-> !pwm_en_ff && phase_ff == '0)
      else $error("pwm running in bright mode");
`endif

endmodule

/* sv/ambient_light_display_dimmer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ambient_light_display_dimmer
// Turns light samples and pwm ticks into led driver display control bytes.
//
// request channel: req_valid / req_stall with req_op (0 sample, 1 tick) and
// req_light. a request is taken when req_valid is high and req_stall low.
// response channel: rsp_valid / rsp_stall with rsp_command and rsp_last;
// rsp_last marks the final command of a request. a request yields zero, one
// or two commands.
// the first command of a request passes the request register and then the
// response queue before it raises rsp_valid.
// throughput: one request per cycle while req_stall stays low, set by the
// single request register; the response port hands out the commands one at
// a time, so a two-command request holds the port for both of them.
// a four-entry response queue parts the two sides; when the receiver stalls
// the queue fills and req_stall rises once fewer than two entries are free.
// reset clears the queue and the request register and puts the dimmer in
// its unknown mode, level 7, pwm off.
// ----------------------------------------------------------------------------
module ambient_light_display_dimmer import ald_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [LIGHT_W-1:0] req_light,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CMD_W-1:0]   rsp_command,
   output logic               rsp_last
);

   ald_push_type push;
   logic         room;

   ald_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .req_light (req_light),
      .room      (room),
      .push      (push)
   );

   ald_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_command (rsp_command),
      .rsp_last    (rsp_last)
   );

endmodule
